// File: rtl/core/nrmc_pkg.sv
// ----------------------------------------------------------------------------
// nrmc_pkg
// Shared types and constants for the RMC sentence parser: ASCII codes,
// register indexes, the captured digit store and the output record.
// ----------------------------------------------------------------------------
package nrmc_pkg;

    // ASCII codes seen by the parser
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SENTENCE_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTURY     = 2'd1;

    localparam logic [23:0] SENTENCE_ID_RST = 24'h524D43;   // "RMC"
    localparam logic [13:0] CENTURY_RST     = 14'd2000;
    localparam logic [13:0] YEAR_MAX        = 14'd9999;

    // Digit slots: time 0..5, latitude 6..9, longitude 10..14, date 15..20
    localparam int NUM_SLOTS = 21;
    localparam int SLOT_W    = 5;

    localparam int TDATA_W = 80;

    typedef logic [NUM_SLOTS-1:0][3:0] digits_t;

    typedef struct packed {
        logic [15:0] longitude_arcmin;
        logic [12:0] latitude_arcmin;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  second;
        logic [6:0]  minute;
        logic [6:0]  hour;
        logic        format_error;
        logic        fix_valid;
    } rec_t;

    // Two BCD-style digits to a binary value
    function automatic logic [6:0] two_dig(input logic [3:0] hi, input logic [3:0] lo);
        return ({3'b000, hi} * 7'd10) + {3'b000, lo};
    endfunction

endpackage

// File: rtl/core/nrmc_record.sv
// ----------------------------------------------------------------------------
// nrmc_record
// Builds the output record from the captured digits, the status flags and
// the century base: two-digit values, arc-minute positions, saturated year.
// ----------------------------------------------------------------------------
module nrmc_record (
    input  nrmc_pkg::digits_t digits,
    input  logic [13:0]       century_base,
    input  logic              fix_valid,
    input  logic              format_error,
    output nrmc_pkg::rec_t    rec
);
    import nrmc_pkg::*;

    logic [6:0]  lat_deg, lat_min, lon_dd, lon_min, yy;
    logic [9:0]  lon_deg;
    logic [14:0] year_sum;

    // Position fields
    assign lat_deg  = two_dig(digits[6], digits[7]);
    assign lat_min  = two_dig(digits[8], digits[9]);
    assign lon_dd   = two_dig(digits[11], digits[12]);
    assign lon_min  = two_dig(digits[13], digits[14]);
    assign lon_deg  = ({6'd0, digits[10]} * 10'd100) + {3'd0, lon_dd};

    // Year with saturation
    assign yy       = two_dig(digits[19], digits[20]);
    assign year_sum = {1'b0, century_base} + {8'd0, yy};

    always_comb begin
        rec.hour             = two_dig(digits[0], digits[1]);
        rec.minute           = two_dig(digits[2], digits[3]);
        rec.second           = two_dig(digits[4], digits[5]);
        rec.day              = two_dig(digits[15], digits[16]);
        rec.month            = two_dig(digits[17], digits[18]);
        rec.year             = (year_sum > {1'b0, YEAR_MAX}) ? YEAR_MAX : year_sum[13:0];
        rec.latitude_arcmin  = ({6'd0, lat_deg} * 13'd60) + {6'd0, lat_min};
        rec.longitude_arcmin = ({6'd0, lon_deg} * 16'd60) + {9'd0, lon_min};
        rec.fix_valid        = fix_valid;
        rec.format_error     = format_error;
    end

endmodule

// File: rtl/core/nmea_rmc_sentence_parser_top.sv
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_parser_top
// NMEA 0183 RMC sentence parser: one received character per input beat,
// one time/date/position record per complete sentence.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries received characters, one per beat (s_tdata[7:0]).
//   m_* carries one record per sentence ended by CR LF; tdata holds the
//   time, date and position fields, tuser the fix and format error flags.
//   cfg_* writes the sentence id (index 0) and century base (index 1),
//   always ready; write only while no sentence is in flight.
//   A character is taken every cycle while s_tready is high. The record
//   is registered when the LF beat is accepted and appears on m_* from the
//   output register. Parsing state updates in a single registered pass per
//   character; the record arithmetic sits between the digit store and the
//   output register.
//   If the receiver stalls, one further record can be held in a skid
//   register; s_tready drops only while that skid register is full.
//   Synchronous active-low reset returns the parser to hunting for '$',
//   empties the output and restores the default registers ("RMC", 2000).
// ----------------------------------------------------------------------------
module nmea_rmc_sentence_parser_top #(
    parameter int MAX_SENTENCE_LEN = 128
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,    // [7:0] rx_byte
    // result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [6:0] hour, [13:7] minute, [20:14] second, [27:21] day,
    // [34:28] month, [48:35] year, [61:49] latitude_arcmin,
    // [77:62] longitude_arcmin, [79:78] zero
    output logic [nrmc_pkg::TDATA_W-1:0]     m_tdata,
    output logic [1:0]                       m_tuser,    // [0] fix_valid, [1] format_error
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [nrmc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [23:0]                      cfg_data
);
    import nrmc_pkg::*;

    localparam int POS_W = $clog2(MAX_SENTENCE_LEN + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_SENTENCE_LEN);
    localparam logic [POS_W-1:0] POS_ID_LAST = POS_W'(5);

    // Parse phases
    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_ID   = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    // Configuration
    logic [23:0] sentence_id_reg;
    logic [13:0] century_reg;

    // Parser state
    logic [1:0]       phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [3:0]       comma_reg, comma_next;
    logic [2:0]       fci_reg, fci_next;
    logic             last_cr_reg, last_cr_next;
    logic [23:0]      id_shift_reg, id_shift_next;
    digits_t          digits_reg, digits_next;
    logic             fix_reg, fix_next;
    logic             err_reg, err_next;

    // Output register and skid register
    rec_t out_reg, out_next, skid_reg, skid_next;
    logic out_valid_reg, out_valid_next, skid_valid_reg, skid_valid_next;

    logic        s_acc, pop, emit, is_digit;
    logic [3:0]  fld_count;
    logic [SLOT_W-1:0] fld_base, slot;
    rec_t        rec;

    assign s_tready  = ~skid_valid_reg;
    assign s_acc     = s_tvalid & s_tready;
    assign pop       = out_valid_reg & m_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.longitude_arcmin, out_reg.latitude_arcmin,
                       out_reg.year, out_reg.month, out_reg.day, out_reg.second,
                       out_reg.minute, out_reg.hour};
    assign m_tuser  = {out_reg.format_error, out_reg.fix_valid};

    // Capture field layout for the current comma count
    always_comb begin
        unique case (comma_reg)
            4'd1:    begin fld_base = SLOT_W'(0);  fld_count = 4'd6; end
            4'd3:    begin fld_base = SLOT_W'(6);  fld_count = 4'd4; end
            4'd5:    begin fld_base = SLOT_W'(10); fld_count = 4'd5; end
            4'd9:    begin fld_base = SLOT_W'(15); fld_count = 4'd6; end
            default: begin fld_base = SLOT_W'(0);  fld_count = 4'd0; end
        endcase
    end

    assign slot     = fld_base + {2'b00, fci_reg};
    assign is_digit = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);

    // Per-character parser update
    always_comb begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        comma_next    = comma_reg;
        fci_next      = fci_reg;
        last_cr_next  = last_cr_reg;
        id_shift_next = id_shift_reg;
        digits_next   = digits_reg;
        fix_next      = fix_reg;
        err_next      = err_reg;
        emit          = 1'b0;

        if (s_acc) begin
            if (phase_reg != PH_ID && phase_reg != PH_BODY) begin
                // hunting for the start character
                phase_next = PH_WAIT;
                if (s_tdata == CH_DOLLAR) begin
                    phase_next    = PH_ID;
                    pos_next      = POS_W'(1);
                    comma_next    = 4'd0;
                    fci_next      = 3'd0;
                    last_cr_next  = 1'b0;
                    id_shift_next = 24'd0;
                    digits_next   = '0;
                    fix_next      = 1'b0;
                    err_next      = 1'b0;
                end
            end else if (pos_reg >= POS_MAX) begin
                // overlong sentence: drop it
                phase_next = PH_WAIT;
            end else begin
                pos_next = pos_reg + POS_W'(1);
                if (phase_reg == PH_ID) begin
                    id_shift_next = {id_shift_reg[15:0], s_tdata};
                    if (pos_reg == POS_ID_LAST)
                        phase_next = (id_shift_next == sentence_id_reg) ? PH_BODY : PH_WAIT;
                end else if (last_cr_reg && s_tdata == CH_LF) begin
                    // end of sentence
                    emit         = 1'b1;
                    if (comma_reg < 4'd9)
                        err_next = 1'b1;
                    phase_next   = PH_WAIT;
                    last_cr_next = 1'b0;
                end else begin
                    last_cr_next = (s_tdata == CH_CR);
                    if (s_tdata == CH_COMMA) begin
                        if ({1'b0, fci_reg} < fld_count)
                            err_next = 1'b1;
                        if (comma_reg != 4'd15)
                            comma_next = comma_reg + 4'd1;
                        fci_next = 3'd0;
                    end else begin
                        if (comma_reg == 4'd2 && fci_reg == 3'd0 && s_tdata == CH_A)
                            fix_next = 1'b1;
                        if ({1'b0, fci_reg} < fld_count) begin
                            for (int i = 0; i < NUM_SLOTS; i++) begin
                                if (slot == SLOT_W'(i))
                                    digits_next[i] = is_digit ? s_tdata[3:0] : 4'd0;
                            end
                            if (!is_digit)
                                err_next = 1'b1;
                        end
                        if (fci_reg != 3'd7)
                            fci_next = fci_reg + 3'd1;
                    end
                end
            end
        end
    end

    // Record arithmetic from the current digits and final flags
    nrmc_record u_record (
        .digits       (digits_reg),
        .century_base (century_reg),
        .fix_valid    (fix_reg),
        .format_error (err_next),
        .rec          (rec)
    );

    // Output register with one-deep skid
    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = rec;
                out_valid_next = emit;
            end
        end else if (emit) begin
            skid_next       = rec;
            skid_valid_next = 1'b1;
        end
    end

    // Control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sentence_id_reg <= SENTENCE_ID_RST;
            century_reg     <= CENTURY_RST;
            phase_reg       <= PH_WAIT;
            pos_reg         <= '0;
            comma_reg       <= 4'd0;
            fci_reg         <= 3'd0;
            last_cr_reg     <= 1'b0;
            fix_reg         <= 1'b0;
            err_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_SENTENCE_ID)
                    sentence_id_reg <= cfg_data;
                else if (cfg_index == REG_CENTURY)
                    century_reg <= cfg_data[13:0];
            end
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            comma_reg      <= comma_next;
            fci_reg        <= fci_next;
            last_cr_reg    <= last_cr_next;
            fix_reg        <= fix_next;
            err_reg        <= err_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        id_shift_reg <= id_shift_next;
        digits_reg   <= digits_next;
        out_reg      <= out_next;
        skid_reg     <= skid_next;
    end

endmodule
